// File: sv/sleep_pressure_swa_step_defines.svh
// Assertion macros for the sleep pressure / SWA step block.
`ifndef SLEEP_PRESSURE_SWA_STEP_DEFINES_SVH
`define SLEEP_PRESSURE_SWA_STEP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/sps_pkg.sv
package sps_pkg;

   localparam int LEVEL_W  = 32;
   localparam int RET_W    = 16;
   localparam int TICK_W   = 9;
   localparam int FACTOR_W = 17;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LEVEL    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LEVEL    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWA_FLOOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAKE_RET       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NREM_RET       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RUMINATION_RET = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SWA_SYNC_RET   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SWA_DESYNC_RET = 3'd7;

   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'd65536;

   typedef struct packed {
      logic                      start_req;
      logic signed [LEVEL_W-1:0] init_pressure;
      logic signed [LEVEL_W-1:0] initial_swa;
      logic        [TICK_W-1:0]  wake_ticks;
      logic        [TICK_W-1:0]  nrem_ticks;
      logic        [TICK_W-1:0]  rumination_ticks;
   } req_payload_type;

   typedef struct packed {
      logic signed [LEVEL_W-1:0] pressure_out;
      logic signed [LEVEL_W-1:0] swa_out;
   } rsp_payload_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIFF  = 6'b000010,
      ST_POW   = 6'b000100,
      ST_SCALE = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef enum logic [2:0] {
      PH_WAKE,
      PH_NREM,
      PH_RUMINATION,
      PH_SYNC,
      PH_DESYNC
   } phase_type;

endpackage

// File: sv/sleep_pressure_swa_step.sv
// Channel  | Ports                          | Carries
// req      | req_valid req_ready req_data   | one scoring epoch (start flag, init, ticks)
// rsp      | rsp_valid rsp_ready rsp_data   | pressure and SWA at end of epoch
// csr      | csr_we csr_index csr_wdata     | eight level / retention registers
//
// Five phases per epoch, each a difference step, the retention power (a squaring step per
// exponent bit, a multiply step per set bit, an exit step), a scale and an add step, all on
// the single 32x17 multiplier. rsp_valid and req_ready rise together when the result
// commits; the next beat can be taken from then on.
// req_ready is high only while the sequencer is idle; a result waiting in the output
// register does not block the next accept, only the commit of the following result.
// Reset (synchronous, active high) clears the configuration, pressure, SWA, state, phase and the output valid.
`include "sleep_pressure_swa_step_defines.svh"

module sleep_pressure_swa_step
   import sps_pkg::*;
#(
   parameter int EPOCH_TICKS       = 256,
   parameter int RUMINATION_LOWERS = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [LEVEL_W-1:0]     csr_wdata
);

   // Exponent width covers both the tick fields and the remainder of the epoch.
   localparam int EPOCH_BITS = $clog2(EPOCH_TICKS + 1);
   localparam int EXP_W      = (EPOCH_BITS > TICK_W) ? EPOCH_BITS : TICK_W;
   localparam logic [EXP_W-1:0] EPOCH_V = EXP_W'(EPOCH_TICKS);
   localparam int PROD_W     = LEVEL_W + FACTOR_W;

   // Configuration registers.
   logic signed [LEVEL_W-1:0] upper_ff, upper_in;
   logic signed [LEVEL_W-1:0] lower_ff, lower_in;
   logic signed [LEVEL_W-1:0] floor_ff, floor_in;
   logic [RET_W-1:0]          wake_ret_ff, wake_ret_in;
   logic [RET_W-1:0]          nrem_ret_ff, nrem_ret_in;
   logic [RET_W-1:0]          rum_ret_ff, rum_ret_in;
   logic [RET_W-1:0]          sync_ret_ff, sync_ret_in;
   logic [RET_W-1:0]          desync_ret_ff, desync_ret_in;

   // Model state and working levels.
   logic signed [LEVEL_W-1:0] pres_ff, pres_in;
   logic signed [LEVEL_W-1:0] swa_ff, swa_in;
   logic signed [LEVEL_W-1:0] pwork_ff, pwork_in;
   logic signed [LEVEL_W-1:0] swork_ff, swork_in;

   // Sequencer and shared-unit operands.
   state_type                 state_ff, state_in;
   phase_type                 phase_ff, phase_in;
   logic [TICK_W-1:0]         tw_ff, tw_in;
   logic [TICK_W-1:0]         tn_ff, tn_in;
   logic [TICK_W-1:0]         tr_ff, tr_in;
   logic [LEVEL_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [FACTOR_W-1:0]       res_ff, res_in;
   logic [RET_W-1:0]          base_ff, base_in;
   logic [EXP_W-1:0]          exp_ff, exp_in;
   logic signed [LEVEL_W:0]   scaled_ff, scaled_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_data_ff, rsp_data_in;

   // Datapath.
   logic signed [LEVEL_W-1:0] x_sel, t_sel, ref_sel;
   logic [RET_W-1:0]          ret_sel;
   logic [EXP_W-1:0]          tick_sel, rest;
   logic signed [LEVEL_W:0]   diff;
   logic [LEVEL_W:0]          diff_abs;
   logic [LEVEL_W-1:0]        mul_a;
   logic [FACTOR_W-1:0]       mul_b;
   logic [PROD_W-1:0]         prod, prod_rnd;
   logic [LEVEL_W:0]          rnd_q;
   logic signed [LEVEL_W+1:0] sum;
   logic signed [LEVEL_W-1:0] sum_sat;
   logic                      commit;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Remaining ticks of the epoch after NREM, clamped at zero.
   assign rest = (EPOCH_V > EXP_W'(tn_ff)) ? EPOCH_V - EXP_W'(tn_ff) : '0;

   // Pick level, target, retention and exponent for the current phase.
   always_comb begin
      x_sel    = pwork_ff;
      t_sel    = lower_ff;
      ret_sel  = nrem_ret_ff;
      tick_sel = EXP_W'(tn_ff);
      case (phase_ff)
         PH_WAKE: begin
            x_sel    = pres_ff;
            t_sel    = upper_ff;
            ret_sel  = wake_ret_ff;
            tick_sel = EXP_W'(tw_ff);
         end
         PH_NREM: begin
            x_sel    = pwork_ff;
            t_sel    = lower_ff;
            ret_sel  = nrem_ret_ff;
            tick_sel = EXP_W'(tn_ff);
         end
         PH_RUMINATION: begin
            x_sel    = pwork_ff;
            t_sel    = (RUMINATION_LOWERS != 0) ? lower_ff : upper_ff;
            ret_sel  = rum_ret_ff;
            tick_sel = EXP_W'(tr_ff);
         end
         PH_SYNC: begin
            // new SWA = p - scale(old p - old SWA) = p + scale(old SWA - old p)
            x_sel    = swa_ff;
            t_sel    = pwork_ff;
            ret_sel  = sync_ret_ff;
            tick_sel = EXP_W'(tn_ff);
         end
         PH_DESYNC: begin
            x_sel    = swork_ff;
            t_sel    = floor_ff;
            ret_sel  = desync_ret_ff;
            tick_sel = rest;
         end
         default: begin
            x_sel    = pwork_ff;
            t_sel    = lower_ff;
            ret_sel  = nrem_ret_ff;
            tick_sel = EXP_W'(tn_ff);
         end
      endcase
   end

   // The sync step scales the old levels' difference but adds it to the new pressure.
   assign ref_sel  = (phase_ff == PH_SYNC) ? pres_ff : t_sel;
   assign diff     = {x_sel[LEVEL_W-1], x_sel} - {ref_sel[LEVEL_W-1], ref_sel};
   assign diff_abs = diff[LEVEL_W] ? (~diff + 1'b1) : diff;

   // Shared multiplier: factor steps in the power loop, magnitude times factor in scale.
   always_comb begin
      mul_a = mag_ff;
      mul_b = res_ff;
      if (state_ff == ST_POW) begin
         mul_b = {1'b0, base_ff};
         if (exp_ff[0]) begin
            mul_a = LEVEL_W'(res_ff);
         end else begin
            mul_a = LEVEL_W'(base_ff);
         end
      end
   end

   assign prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_rnd = prod + PROD_W'(32768);
   assign rnd_q    = prod_rnd[PROD_W-1:16];

   // Add the scaled difference to the target and clip to the 32-bit range.
   assign sum = {{2{t_sel[LEVEL_W-1]}}, t_sel} + {scaled_ff[LEVEL_W], scaled_ff};
   always_comb begin
      if (sum[LEVEL_W+1:LEVEL_W-1] == 3'b000 || sum[LEVEL_W+1:LEVEL_W-1] == 3'b111) begin
         sum_sat = sum[LEVEL_W-1:0];
      end else if (sum[LEVEL_W+1]) begin
         sum_sat = {1'b1, {(LEVEL_W-1){1'b0}}};
      end else begin
         sum_sat = {1'b0, {(LEVEL_W-1){1'b1}}};
      end
   end

   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Configuration writes.
   always_comb begin
      upper_in      = upper_ff;
      lower_in      = lower_ff;
      floor_in      = floor_ff;
      wake_ret_in   = wake_ret_ff;
      nrem_ret_in   = nrem_ret_ff;
      rum_ret_in    = rum_ret_ff;
      sync_ret_in   = sync_ret_ff;
      desync_ret_in = desync_ret_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_UPPER_LEVEL:    upper_in      = csr_wdata;
            CSR_LOWER_LEVEL:    lower_in      = csr_wdata;
            CSR_SWA_FLOOR:      floor_in      = csr_wdata;
            CSR_WAKE_RET:       wake_ret_in   = csr_wdata[RET_W-1:0];
            CSR_NREM_RET:       nrem_ret_in   = csr_wdata[RET_W-1:0];
            CSR_RUMINATION_RET: rum_ret_in    = csr_wdata[RET_W-1:0];
            CSR_SWA_SYNC_RET:   sync_ret_in   = csr_wdata[RET_W-1:0];
            CSR_SWA_DESYNC_RET: desync_ret_in = csr_wdata[RET_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      tw_in        = tw_ff;
      tn_in        = tn_ff;
      tr_in        = tr_ff;
      pres_in      = pres_ff;
      swa_in       = swa_ff;
      pwork_in     = pwork_ff;
      swork_in     = swork_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      base_in      = base_ff;
      exp_in       = exp_ff;
      scaled_in    = scaled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Latch the beat; a start flag reloads the state first.
               tw_in    = req_data.wake_ticks;
               tn_in    = req_data.nrem_ticks;
               tr_in    = req_data.rumination_ticks;
               phase_in = PH_WAKE;
               state_in = ST_DIFF;
               if (req_data.start_req) begin
                  pres_in = req_data.init_pressure;
                  swa_in  = req_data.initial_swa;
               end
            end
         end
         ST_DIFF: begin
            // Hold the magnitude and sign of the difference; seed the power loop.
            mag_in   = diff_abs[LEVEL_W-1:0];
            neg_in   = diff[LEVEL_W];
            res_in   = FACTOR_ONE;
            base_in  = ret_sel;
            exp_in   = tick_sel;
            state_in = ST_POW;
         end
         ST_POW: begin
            if (exp_ff == '0) begin
               state_in = ST_SCALE;
            end else if (exp_ff[0]) begin
               // Multiply the set bit in, then drop it.
               res_in = rnd_q[FACTOR_W-1:0];
               exp_in = {exp_ff[EXP_W-1:1], 1'b0};
            end else begin
               // Square the base and advance one bit.
               base_in = rnd_q[RET_W-1:0];
               exp_in  = exp_ff >> 1;
            end
         end
         ST_SCALE: begin
            // Round to nearest, ties away from zero, by scaling the magnitude.
            scaled_in = neg_ff ? -$signed({1'b0, rnd_q[LEVEL_W-1:0]})
                               : $signed({1'b0, rnd_q[LEVEL_W-1:0]});
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            if (phase_ff == PH_SYNC || phase_ff == PH_DESYNC) begin
               swork_in = sum_sat;
            end else begin
               pwork_in = sum_sat;
            end
            case (phase_ff)
               PH_WAKE:       phase_in = PH_NREM;
               PH_NREM:       phase_in = PH_RUMINATION;
               PH_RUMINATION: phase_in = PH_SYNC;
               PH_SYNC:       phase_in = PH_DESYNC;
               default:       phase_in = PH_DESYNC;
            endcase
            state_in = (phase_ff == PH_DESYNC) ? ST_DONE : ST_DIFF;
         end
         ST_DONE: begin
            // Wait for the output register to free, then commit state and result.
            if (commit) begin
               pres_in                  = pwork_ff;
               swa_in                   = swork_ff;
               rsp_data_in.pressure_out = pwork_ff;
               rsp_data_in.swa_out      = swork_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_ff      <= '0;
         lower_ff      <= '0;
         floor_ff      <= '0;
         wake_ret_ff   <= '0;
         nrem_ret_ff   <= '0;
         rum_ret_ff    <= '0;
         sync_ret_ff   <= '0;
         desync_ret_ff <= '0;
         pres_ff       <= '0;
         swa_ff        <= '0;
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_WAKE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         upper_ff      <= upper_in;
         lower_ff      <= lower_in;
         floor_ff      <= floor_in;
         wake_ret_ff   <= wake_ret_in;
         nrem_ret_ff   <= nrem_ret_in;
         rum_ret_ff    <= rum_ret_in;
         sync_ret_ff   <= sync_ret_in;
         desync_ret_ff <= desync_ret_in;
         pres_ff       <= pres_in;
         swa_ff        <= swa_in;
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tw_ff       <= tw_in;
      tn_ff       <= tn_in;
      tr_ff       <= tr_in;
      pwork_ff    <= pwork_in;
      swork_ff    <= swork_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      base_ff     <= base_in;
      exp_ff      <= exp_in;
      scaled_ff   <= scaled_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SPS_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
   `SPS_ASSERT_NEXT(a_pow_exit, state_ff == ST_POW && exp_ff == '0, state_ff == ST_SCALE, "pow exit")
   `SPS_ASSERT_NOW(a_factor_bounded, state_ff == ST_POW, res_ff <= FACTOR_ONE, "factor above one")
   `SPS_ASSERT_NEXT(a_commit_matches, commit, rsp_valid && rsp_data.pressure_out == pres_ff && rsp_data.swa_out == swa_ff, "commit mismatch")

endmodule

// File: tb/sleep_epoch_tb_pkg.sv
package sleep_epoch_tb_pkg;
   import sps_pkg::*;

   // Build parameters the block is instantiated with.
   localparam int EPOCH_LEN           = 256;
   localparam int RUMINATION_TO_LOWER = 1;

   localparam logic [LEVEL_W-1:0] LEVEL_MAX = 32'h7FFF_FFFF;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN = 32'h8000_0000;

   class sleep_epoch_scoreboard;
      longint          upper_level;
      longint          lower_level;
      longint          swa_floor;
      logic [RET_W-1:0] wake_ret;
      logic [RET_W-1:0] nrem_ret;
      logic [RET_W-1:0] rumination_ret;
      logic [RET_W-1:0] sync_ret;
      logic [RET_W-1:0] desync_ret;
      longint          pressure;
      longint          swa_level;
      rsp_payload_type epoch_result_q[$];
      int              fail_count;
      int              result_count;

      function new();
         upper_level    = 0;
         lower_level    = 0;
         swa_floor      = 0;
         wake_ret       = '0;
         nrem_ret       = '0;
         rumination_ret = '0;
         sync_ret       = '0;
         desync_ret     = '0;
         pressure       = 0;
         swa_level      = 0;
         fail_count     = 0;
         result_count   = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [LEVEL_W-1:0] data);
         case (idx)
            CSR_UPPER_LEVEL:    upper_level    = longint'($signed(data));
            CSR_LOWER_LEVEL:    lower_level    = longint'($signed(data));
            CSR_SWA_FLOOR:      swa_floor      = longint'($signed(data));
            CSR_WAKE_RET:       wake_ret       = data[RET_W-1:0];
            CSR_NREM_RET:       nrem_ret       = data[RET_W-1:0];
            CSR_RUMINATION_RET: rumination_ret = data[RET_W-1:0];
            CSR_SWA_SYNC_RET:   sync_ret       = data[RET_W-1:0];
            CSR_SWA_DESYNC_RET: desync_ret     = data[RET_W-1:0];
            default: ;
         endcase
      endfunction

      // r^n with r in Q0.16 and the result in Q1.16, square-and-multiply from the low exponent bit.
      function longint unsigned retention_power(logic [RET_W-1:0] r, int unsigned n);
         longint unsigned acc;
         longint unsigned base;
         acc  = longint'(FACTOR_ONE);
         base = r;
         for (int i = 0; i < FACTOR_W; i++) begin
            if (((n >> i) & 1) != 0)
               acc = (acc * base + 64'd32768) >> 16;
            base = (base * base + 64'd32768) >> 16;
         end
         return acc;
      endfunction

      // d * f / 2^16, rounded to nearest with ties away from zero.
      function longint scale_level(longint d, longint unsigned f);
         longint unsigned mag;
         longint unsigned prod;
         mag  = (d < 0) ? longint'(-d) : d;
         prod = (mag * f + 64'd32768) >> 16;
         return (d < 0) ? -longint'(prod) : longint'(prod);
      endfunction

      function longint clip_level(longint x);
         if (x > 64'sd2147483647)
            return 64'sd2147483647;
         if (x < -64'sd2147483648)
            return -64'sd2147483648;
         return x;
      endfunction

      function longint relax_level(longint x, longint target, longint unsigned f);
         return clip_level(target + scale_level(x - target, f));
      endfunction

      function void note_epoch(req_payload_type e);
         longint          p;
         longint          s;
         int unsigned     rest;
         rsp_payload_type predicted;
         if (e.start_req) begin
            pressure  = longint'($signed(e.init_pressure));
            swa_level = longint'($signed(e.initial_swa));
         end
         p = relax_level(pressure, upper_level, retention_power(wake_ret, e.wake_ticks));
         p = relax_level(p, lower_level, retention_power(nrem_ret, e.nrem_ticks));
         p = relax_level(p, (RUMINATION_TO_LOWER != 0) ? lower_level : upper_level,
                         retention_power(rumination_ret, e.rumination_ticks));
         s = clip_level(p - scale_level(pressure - swa_level,
                                        retention_power(sync_ret, e.nrem_ticks)));
         rest = (EPOCH_LEN > int'(e.nrem_ticks)) ? EPOCH_LEN - e.nrem_ticks : 0;
         s = relax_level(s, swa_floor, retention_power(desync_ret, rest));
         pressure  = p;
         swa_level = s;
         predicted.pressure_out = p[LEVEL_W-1:0];
         predicted.swa_out      = s[LEVEL_W-1:0];
         epoch_result_q.push_back(predicted);
      endfunction

      task report(string msg);
         fail_count++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      task check_result(rsp_payload_type got);
         rsp_payload_type want;
         result_count++;
         if (epoch_result_q.size() == 0) begin
            report($sformatf("result %0d arrived with no epoch pending", result_count));
         end else begin
            want = epoch_result_q.pop_front();
            if (got.pressure_out !== want.pressure_out)
               report($sformatf("result %0d pressure_out got %h want %h",
                                result_count, got.pressure_out, want.pressure_out));
            if (got.swa_out !== want.swa_out)
               report($sformatf("result %0d swa_out got %h want %h",
                                result_count, got.swa_out, want.swa_out));
         end
      endtask

      function int pending();
         return epoch_result_q.size();
      endfunction

      task flush_leftovers();
         while (epoch_result_q.size() != 0) begin
            void'(epoch_result_q.pop_front());
            report("epoch result never delivered");
         end
      endtask
   endclass

endpackage

// File: tb/tb_top.sv
module tb_top;
   import sps_pkg::*;
   import sleep_epoch_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_payload_type      req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_payload_type      rsp_data;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [LEVEL_W-1:0]   csr_wdata;

   sleep_epoch_scoreboard sb = new();

   // Beats left in the current sender burst; zero means pause before the next.
   int burst_left = 0;

   sleep_pressure_swa_step #(
      .EPOCH_TICKS      (EPOCH_LEN),
      .RUMINATION_LOWERS(RUMINATION_TO_LOWER)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Hard stop: sized for the worst epoch (longest power chains, sender gap and
   // receiver stall) over about 1220 epochs, with a wide margin.
   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic req_payload_type make_epoch(logic start, logic [LEVEL_W-1:0] ip,
                                                  logic [LEVEL_W-1:0] is, int w, int n,
                                                  int r);
      req_payload_type e;
      e.start_req        = start;
      e.init_pressure    = ip;
      e.initial_swa      = is;
      e.wake_ticks       = w[TICK_W-1:0];
      e.nrem_ticks       = n[TICK_W-1:0];
      e.rumination_ticks = r[TICK_W-1:0];
      return e;
   endfunction

   // Tick counts at the corners: empty, one, around a full epoch, field maximum.
   function automatic int tick_corner();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 1;
         2:       return EPOCH_LEN - 1;
         3:       return EPOCH_LEN;
         4:       return EPOCH_LEN + 1;
         default: return (1 << TICK_W) - 1;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return LEVEL_MAX;
         1:       return LEVEL_MIN;
         2, 3:    return $urandom;
         // plausible Q16.16 values within +/- 8.0
         default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
      endcase
   endfunction

   function automatic logic [LEVEL_W-1:0] pick_retention();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'h0000_FFFF;
         2, 3:    return $urandom_range(60000, 65535);
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic req_payload_type random_epoch();
      req_payload_type e;
      int              w;
      int              n;
      int              r;
      case ($urandom_range(0, 9))
         // well-formed epoch: the three states share at most one epoch of ticks
         0, 1, 2, 3, 4, 5: begin
            n = $urandom_range(0, EPOCH_LEN);
            w = $urandom_range(0, EPOCH_LEN - n);
            r = $urandom_range(0, EPOCH_LEN - n - w);
         end
         6, 7: begin
            w = $urandom_range(0, (1 << TICK_W) - 1);
            n = $urandom_range(0, (1 << TICK_W) - 1);
            r = $urandom_range(0, (1 << TICK_W) - 1);
         end
         8: begin
            w = tick_corner();
            n = tick_corner();
            r = tick_corner();
         end
         default: begin
            // whole epoch in one state
            w = 0;
            n = 0;
            r = 0;
            case ($urandom_range(0, 2))
               0:       w = EPOCH_LEN;
               1:       n = EPOCH_LEN;
               default: r = EPOCH_LEN;
            endcase
         end
      endcase
      // start is rare so that state carries across long runs of epochs
      e = make_epoch($urandom_range(0, 11) == 0, pick_level(), pick_level(), w, n, r);
      return e;
   endfunction

   // Present one beat, hold it until accepted, then record the prediction.
   // Between bursts drop valid for a random gap, which may also be none.
   task automatic send_epoch(input req_payload_type e);
      int gap;
      if (burst_left == 0) begin
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(30, 60);
            default: gap = $urandom_range(1, 8);
         endcase
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= e;
      do @(posedge clock); while (!req_ready);
      sb.note_epoch(e);
   endtask

   // Drop valid and wait for every outstanding result, so the block sits idle.
   task automatic drain_epochs();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [LEVEL_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic randomize_config();
      // skip some registers so that older settings carry into new mixes
      if ($urandom_range(0, 3) != 0) write_register(CSR_UPPER_LEVEL, pick_level());
      if ($urandom_range(0, 3) != 0) write_register(CSR_LOWER_LEVEL, pick_level());
      if ($urandom_range(0, 3) != 0) write_register(CSR_SWA_FLOOR, pick_level());
      if ($urandom_range(0, 3) != 0) write_register(CSR_WAKE_RET, pick_retention());
      if ($urandom_range(0, 3) != 0) write_register(CSR_NREM_RET, pick_retention());
      if ($urandom_range(0, 3) != 0) write_register(CSR_RUMINATION_RET, pick_retention());
      if ($urandom_range(0, 3) != 0) write_register(CSR_SWA_SYNC_RET, pick_retention());
      if ($urandom_range(0, 3) != 0) write_register(CSR_SWA_DESYNC_RET, pick_retention());
      end_writes();
   endtask

   // Result side: sample at the rising edge, change ready at the falling edge.
   // The stall pattern is rerolled as cyc advances: always ready, a duty
   // cycle, coin flips, or long stalls.
   initial begin
      int cyc;
      int mode;
      int period;
      int on_len;
      cyc    = 0;
      mode   = 0;
      period = 1;
      on_len = 1;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_data);
         @(negedge clock);
         if (cyc % 256 == 0) begin
            mode   = $urandom_range(0, 3);
            period = (mode == 3) ? 40 : $urandom_range(2, 16);
            on_len = (mode == 3) ? 5 : $urandom_range(1, period);
         end
         case (mode)
            0:       rsp_ready <= 1'b1;
            2:       rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= (cyc % period) < on_len;
         endcase
         cyc++;
      end
   end

   initial begin
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      reset     = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers at reset (all zero). No start yet, so state runs from zero;
      // zero retention means no change for zero ticks and a jump for any tick.
      send_epoch(make_epoch(1'b0, '0, '0, 0, 0, 0));
      send_epoch(make_epoch(1'b0, LEVEL_MAX, LEVEL_MAX, 1, 1, 1));
      send_epoch(make_epoch(1'b1, LEVEL_MAX, LEVEL_MIN, 0, 0, 0));
      send_epoch(make_epoch(1'b1, LEVEL_MIN, LEVEL_MAX, 511, 511, 511));
      drain_epochs();

      // Asymptotes at the range limits and retention at its largest: drives
      // the saturation paths and NREM at and beyond a full epoch.
      write_register(CSR_UPPER_LEVEL, LEVEL_MAX);
      write_register(CSR_LOWER_LEVEL, LEVEL_MIN);
      write_register(CSR_SWA_FLOOR, LEVEL_MAX);
      write_register(CSR_WAKE_RET, 32'h0000_FFFF);
      write_register(CSR_NREM_RET, 32'h0000_FFFF);
      write_register(CSR_RUMINATION_RET, 32'h0000_FFFF);
      write_register(CSR_SWA_SYNC_RET, 32'h0000_FFFF);
      write_register(CSR_SWA_DESYNC_RET, 32'h0000_FFFF);
      end_writes();
      send_epoch(make_epoch(1'b1, LEVEL_MAX, LEVEL_MIN, 256, 256, 256));
      send_epoch(make_epoch(1'b1, LEVEL_MIN, LEVEL_MAX, 511, 300, 511));
      send_epoch(make_epoch(1'b0, '0, '0, 255, 257, 0));
      send_epoch(make_epoch(1'b1, '0, '0, 1, 0, 0));
      drain_epochs();

      // A plausible setting: upper 2.0, lower -1.0, floor 0.5, with a
      // jump-to-target wake, a frozen NREM and a one-tick SWA desync.
      write_register(CSR_UPPER_LEVEL, 32'h0002_0000);
      write_register(CSR_LOWER_LEVEL, 32'hFFFF_0000);
      write_register(CSR_SWA_FLOOR, 32'h0000_8000);
      write_register(CSR_WAKE_RET, 32'd0);
      write_register(CSR_NREM_RET, 32'h0000_FFFF);
      write_register(CSR_RUMINATION_RET, 32'h0000_8000);
      write_register(CSR_SWA_SYNC_RET, 32'd0);
      write_register(CSR_SWA_DESYNC_RET, 32'd1);
      end_writes();
      send_epoch(make_epoch(1'b1, 32'h0000_8000, 32'h0000_1999, 128, 100, 28));
      send_epoch(make_epoch(1'b0, '0, '0, 0, 256, 0));
      send_epoch(make_epoch(1'b0, '0, '0, 256, 0, 0));
      send_epoch(make_epoch(1'b0, '0, '0, 0, 0, 256));
      send_epoch(make_epoch(1'b1, LEVEL_MAX, LEVEL_MAX, 1, 2, 3));
      send_epoch(make_epoch(1'b1, LEVEL_MIN, LEVEL_MIN, 0, 0, 0));
      send_epoch(make_epoch(1'b0, '0, '0, 100, 156, 0));
      send_epoch(make_epoch(1'b0, '0, '0, 511, 511, 511));

      // Random part: eight settings, 150 epochs each.
      for (int ph = 0; ph < 8; ph++) begin
         drain_epochs();
         randomize_config();
         repeat (150) send_epoch(random_epoch());
      end

      drain_epochs();
      // let any stray result surface: longer than the slowest epoch
      repeat (150) @(posedge clock);
      sb.flush_leftovers();
      if (sb.fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
